/* rtl/websocket_frame_receiver_top_assert.svh */
// Assertion macros shared by the WebSocket frame receiver RTL.
// Included by modules that check their own control logic; no dependencies.
`ifndef WEBSOCKET_FRAME_RECEIVER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WSFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define WSFR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/wsfr_pkg.sv */
// Package for the WebSocket frame receiver: phase type, result codes and result struct.
// No dependencies; imported by wsfr_parser and websocket_frame_receiver_top.
package wsfr_pkg;

   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_LEN1    = 3'd1,
      PH_LEN2    = 3'd2,
      PH_LEN8    = 3'd3,
      PH_MASK    = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_HALT    = 3'd6
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [7:0] MASK_BIT   = 8'h80;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic [3:0] opcode;
      logic       last;
   } result_type;

endpackage

/* rtl/websocket_frame_receiver_top.sv */
// Top level of the WebSocket frame receiver: input register, parser, result register.
// Depends on wsfr_pkg and wsfr_parser.
//
// Usage: the request channel carries one byte of the frame stream per
// transaction (req_valid, req_stall, req_in_byte). The response channel carries
// at most one result per byte: a payload byte unmasked with the frame's key,
// an empty-frame marker, or a length error (rsp_kind, rsp_payload,
// rsp_frame_opcode, rsp_last_of_frame). Other header bytes produce no transaction.
// A byte is held in an input register, parsed and unmasked combinationally,
// and its result is loaded into the response register, from which it is
// offered on the response channel. One byte is accepted per cycle while the
// response side keeps up; the rate is set by the single parser stage
// between the two registers.
// When rsp_stall is high with a result pending, the pipeline holds and
// req_stall rises once the input register is occupied.
// Synchronous reset returns the parser to waiting for an opcode byte and
// empties both registers. After a length error all later bytes are
// accepted and dropped until reset.
module websocket_frame_receiver_top import wsfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_payload,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_last_of_frame
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       out_free;
   logic       fire;
   logic       res_valid;
   result_type res;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   wsfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .in_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_payload       = out_ff.payload;
   assign rsp_frame_opcode  = out_ff.opcode;
   assign rsp_last_of_frame = out_ff.last;

endmodule

/* rtl/wsfr_parser.sv */
// Frame header parser and payload unmasker: one byte per enabled cycle.
// Depends on wsfr_pkg and websocket_frame_receiver_top_assert.svh.
`include "websocket_frame_receiver_top_assert.svh"

module wsfr_parser import wsfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] in_byte,
   output logic       res_valid,
   output result_type res
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  offset_ff, offset_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] count_inc;
   logic        upper_ff, upper_in;
   logic        len_done;
   logic [7:0]  key_byte;

   always_comb begin
      case (count_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign count_inc = count_ff + 32'd1;

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      key_in    = key_ff;
      length_in = length_ff;
      count_in  = count_ff;
      upper_in  = upper_ff;
      len_done  = 1'b0;
      res_valid = 1'b0;
      res       = '{kind: KIND_PAYLOAD, payload: 8'd0, opcode: opcode_ff, last: 1'b0};
      unique case (phase_ff)
         PH_OPCODE: begin
            opcode_in = in_byte[3:0];
            phase_in  = PH_LEN1;
         end
         PH_LEN1: begin
            masked_in = (in_byte & MASK_BIT) != 8'd0;
            offset_in = 3'd0;
            length_in = 32'd0;
            upper_in  = 1'b0;
            if (in_byte[6:0] < LEN7_EXT16) begin
               length_in = {25'd0, in_byte[6:0]};
               len_done  = 1'b1;
            end else if (in_byte[6:0] == LEN7_EXT16) begin
               phase_in = PH_LEN2;
            end else begin
               phase_in = PH_LEN8;
            end
         end
         PH_LEN2: begin
            length_in = {length_ff[23:0], in_byte};
            offset_in = offset_ff + 3'd1;
            len_done  = (offset_in == 3'd2);
         end
         PH_LEN8: begin
            if (!offset_ff[2]) begin
               upper_in = upper_ff | (in_byte != 8'd0);
            end else begin
               length_in = {length_ff[23:0], in_byte};
            end
            if (offset_ff == 3'd7) begin
               offset_in = 3'd0;
               if (upper_ff) begin
                  phase_in  = PH_HALT;
                  res_valid = 1'b1;
                  res.kind  = KIND_ERROR;
                  res.last  = 1'b1;
               end else begin
                  len_done = 1'b1;
               end
            end else begin
               offset_in = offset_ff + 3'd1;
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], in_byte};
            if (offset_ff >= 3'd3) begin
               offset_in = 3'd0;
               if (length_ff == 32'd0) begin
                  phase_in  = PH_OPCODE;
                  res_valid = 1'b1;
                  res.kind  = KIND_EMPTY;
                  res.last  = 1'b1;
               end else begin
                  count_in = 32'd0;
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               offset_in = offset_ff + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            count_in    = count_inc;
            res_valid   = 1'b1;
            res.payload = masked_ff ? (in_byte ^ key_byte) : in_byte;
            if (count_inc == length_ff) begin
               phase_in = PH_OPCODE;
               res.last = 1'b1;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      if (len_done) begin
         if (masked_in) begin
            offset_in = 3'd0;
            phase_in  = PH_MASK;
         end else if (length_in == 32'd0) begin
            phase_in  = PH_OPCODE;
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.last  = 1'b1;
         end else begin
            count_in = 32'd0;
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         offset_ff <= 3'd0;
         opcode_ff <= 4'd0;
         masked_ff <= 1'b0;
         key_ff    <= 32'd0;
         length_ff <= 32'd0;
         count_ff  <= 32'd0;
         upper_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         key_ff    <= key_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         upper_ff  <= upper_in;
      end
   end

   // Once an error has been reported, the parser never leaves the halted phase.
   `WSFR_ASSERT_NXT(a_halt_sticky, clock, reset, phase_ff == PH_HALT, phase_ff == PH_HALT)
   `WSFR_ASSERT_IMP(a_error_src, clock, reset, res_valid && res.kind == KIND_ERROR,
      phase_ff == PH_LEN8 && offset_ff == 3'd7 && upper_ff)
   `WSFR_ASSERT_IMP(a_non_payload, clock, reset, res_valid && res.kind != KIND_PAYLOAD,
      res.payload == 8'd0 && res.last)
   `WSFR_ASSERT_IMP(a_payload_result, clock, reset, phase_ff == PH_PAYLOAD, res_valid)

endmodule

/* tb/sv/websocket_frame_receiver_top_tb.sv */
// Self-checking testbench for websocket_frame_receiver_top: sends framed byte streams
// and checks every result against a byte-level frame parser kept in this file.
// Depends on wsfr_pkg and the websocket_frame_receiver_top RTL.
module websocket_frame_receiver_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wsfr_pkg::*;

   typedef enum {FORM_SHORT, FORM_16, FORM_64} length_form_type;

   localparam logic [6:0] LEN7_EXT64    = 7'd127;
   localparam int         RANDOM_ITEMS  = 1100;
   localparam int         STEADY_ITEMS  = 300;
   localparam int         IDLE_PERCENT  = 23;
   localparam int         HOLD_CYCLES   = 80;
   localparam int         DRAIN_CYCLES  = 20;
   localparam int         MAX_PRINTED   = 200;
   localparam longint     RUN_LIMIT_NS  = 5_000_000;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_payload;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_last_of_frame;

   phase_type   hdr_phase;
   logic [2:0]  hdr_offset;
   logic [3:0]  hdr_opcode;
   logic        hdr_masked;
   logic [31:0] hdr_key;
   logic [31:0] frame_len;
   logic [31:0] unmasked_count;
   logic        upper_seen;

   result_type  parsed_results[$];
   int          mismatch_count = 0;
   int          sent_items     = 0;
   bit          steady_run     = 1'b1;
   int          hold_grants    = 0;
   int          hold_seen      = 0;
   int          hold_left      = 0;

   websocket_frame_receiver_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_payload       (rsp_payload),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic last);
      result_type r;
      r.kind    = kind;
      r.payload = data;
      r.opcode  = hdr_opcode;
      r.last    = last;
      parsed_results.push_back(r);
   endfunction

   function automatic void finish_length();
      if (hdr_masked) begin
         hdr_offset = 3'd0;
         hdr_phase  = PH_MASK;
      end else if (frame_len == 32'd0) begin
         hdr_phase = PH_OPCODE;
         push_result(KIND_EMPTY, 8'h00, 1'b1);
      end else begin
         unmasked_count = 32'd0;
         hdr_phase      = PH_PAYLOAD;
      end
   endfunction

   function automatic void reset_parser();
      hdr_phase      = PH_OPCODE;
      hdr_offset     = 3'd0;
      hdr_opcode     = 4'd0;
      hdr_masked     = 1'b0;
      hdr_key        = 32'd0;
      frame_len      = 32'd0;
      unmasked_count = 32'd0;
      upper_seen     = 1'b0;
   endfunction

   function automatic void parse_stream_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      logic       last;
      case (hdr_phase)
         PH_OPCODE: begin
            hdr_opcode = b[3:0];
            hdr_phase  = PH_LEN1;
         end
         PH_LEN1: begin
            hdr_masked = (b & MASK_BIT) != 8'h00;
            hdr_offset = 3'd0;
            frame_len  = 32'd0;
            upper_seen = 1'b0;
            if (b[6:0] < LEN7_EXT16) begin
               frame_len = {25'd0, b[6:0]};
               finish_length();
            end else if (b[6:0] == LEN7_EXT16) begin
               hdr_phase = PH_LEN2;
            end else begin
               hdr_phase = PH_LEN8;
            end
         end
         PH_LEN2: begin
            frame_len  = {frame_len[23:0], b};
            hdr_offset = hdr_offset + 3'd1;
            if (hdr_offset == 3'd2) finish_length();
         end
         PH_LEN8: begin
            if (hdr_offset < 3'd4) begin
               if (b != 8'h00) upper_seen = 1'b1;
            end else begin
               frame_len = {frame_len[23:0], b};
            end
            if (hdr_offset == 3'd7) begin
               hdr_offset = 3'd0;
               if (upper_seen) begin
                  hdr_phase = PH_HALT;
                  push_result(KIND_ERROR, 8'h00, 1'b1);
               end else begin
                  finish_length();
               end
            end else begin
               hdr_offset = hdr_offset + 3'd1;
            end
         end
         PH_MASK: begin
            hdr_key = {hdr_key[23:0], b};
            if (hdr_offset >= 3'd3) begin
               hdr_offset = 3'd0;
               if (frame_len == 32'd0) begin
                  hdr_phase = PH_OPCODE;
                  push_result(KIND_EMPTY, 8'h00, 1'b1);
               end else begin
                  unmasked_count = 32'd0;
                  hdr_phase      = PH_PAYLOAD;
               end
            end else begin
               hdr_offset = hdr_offset + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            key_byte       = hdr_masked ? hdr_key[8 * (3 - unmasked_count[1:0]) +: 8] : 8'h00;
            unmasked_count = unmasked_count + 32'd1;
            last           = unmasked_count == frame_len;
            if (last) hdr_phase = PH_OPCODE;
            push_result(KIND_PAYLOAD, b ^ key_byte, last);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      parse_stream_byte(b);
      sent_items++;
   endtask

   task automatic send_frame(input logic [7:0] op_byte, input logic masked,
                             input length_form_type form, input logic [31:0] len,
                             input logic [31:0] upper, input logic [31:0] key);
      logic [7:0]  mbit;
      logic [63:0] len64;
      mbit  = masked ? MASK_BIT : 8'h00;
      len64 = {upper, len};
      send_byte(op_byte);
      case (form)
         FORM_SHORT: send_byte(mbit | {1'b0, len[6:0]});
         FORM_16: begin
            send_byte(mbit | {1'b0, LEN7_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte(mbit | {1'b0, LEN7_EXT64});
            for (int i = 0; i < 8; i++) send_byte(len64[63 - 8 * i -: 8]);
         end
      endcase
      if (upper == 32'd0) begin
         if (masked) for (int i = 0; i < 4; i++) send_byte(key[31 - 8 * i -: 8]);
         for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic test_unmasked_extremes();
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'hff);
   endtask

   task automatic test_empty_frames();
      send_frame(8'hff, 1'b0, FORM_SHORT, 32'd0, 32'd0, 32'd0);
      send_frame(8'h05, 1'b1, FORM_SHORT, 32'd0, 32'd0, 32'hffff_ffff);
   endtask

   task automatic test_masked_payload();
      send_frame(8'h81, 1'b1, FORM_SHORT, 32'd5, 32'd0, 32'h01ff_80a5);
   endtask

   task automatic test_extended_lengths();
      send_frame(8'h02, 1'b0, FORM_16, 32'd1, 32'd0, 32'd0);
      send_frame(8'h09, 1'b0, FORM_64, 32'd1, 32'd0, 32'd0);
   endtask

   task automatic test_output_backpressure();
      hold_grants++;
      send_frame(8'h01, 1'b1, FORM_SHORT, 32'd40, 32'd0, $urandom);
   endtask

   task automatic test_random_frames();
      int              start;
      int              pick;
      length_form_type form;
      logic [31:0]     len;
      start = sent_items;
      while (sent_items - start < RANDOM_ITEMS) begin
         steady_run = (sent_items - start) < STEADY_ITEMS;
         pick = $urandom_range(99);
         if (pick < 70) begin
            form = FORM_SHORT;
            len  = (pick < 5) ? $urandom_range(125, 13) : $urandom_range(12, 0);
         end else begin
            form = (pick < 85) ? FORM_16 : FORM_64;
            len  = (pick % 5 == 0) ? $urandom_range(300, 250) : $urandom_range(20, 0);
         end
         send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), form, len, 32'd0,
                    $urandom);
      end
      steady_run = 1'b0;
   endtask

   task automatic test_length_error_halt();
      send_frame(8'h08, 1'b0, FORM_64, $urandom, 32'h0000_0001, 32'd0);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h80);
      for (int i = 0; i < 9; i++) send_byte(8'($urandom_range(255)));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (parsed_results.size() == 0) begin
            report_mismatch("result with none due, kind", rsp_kind, 0);
         end else begin
            if (rsp_kind != parsed_results[0].kind)
               report_mismatch("kind", rsp_kind, parsed_results[0].kind);
            if (rsp_payload != parsed_results[0].payload)
               report_mismatch("payload", rsp_payload, parsed_results[0].payload);
            if (rsp_frame_opcode != parsed_results[0].opcode)
               report_mismatch("frame_opcode", rsp_frame_opcode, parsed_results[0].opcode);
            if (rsp_last_of_frame != parsed_results[0].last)
               report_mismatch("last_of_frame", rsp_last_of_frame, parsed_results[0].last);
            void'(parsed_results.pop_front());
         end
      end
      if (hold_grants != hold_seen) begin
         hold_seen = hold_grants;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady_run && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   initial begin
      reset_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unmasked_extremes();
      test_empty_frames();
      test_masked_payload();
      test_extended_lengths();
      steady_run = 1'b0;
      test_output_backpressure();
      test_random_frames();
      test_output_backpressure();
      test_length_error_halt();
      req_valid <= 1'b0;
      while (parsed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/wsfr_pkg.sv
rtl/wsfr_parser.sv
rtl/websocket_frame_receiver_top.sv
tb/sv/websocket_frame_receiver_top_tb.sv
